// ----- sv/utf8lv_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8lv_pkg
// Types, constants and code point classifiers for the UTF-8 label validator.
// ----------------------------------------------------------------------------
package utf8lv_pkg;

    localparam int CP_W  = 21;
    localparam int MIN_W = 17;

    // Lead byte bounds
    localparam logic [7:0] LEAD2_LO = 8'hc2;
    localparam logic [7:0] LEAD2_HI = 8'hdf;
    localparam logic [7:0] LEAD3_LO = 8'he0;
    localparam logic [7:0] LEAD3_HI = 8'hef;
    localparam logic [7:0] LEAD4_LO = 8'hf0;
    localparam logic [7:0] LEAD4_HI = 8'hf4;

    // Smallest legal value for each sequence length
    localparam logic [MIN_W-1:0] MIN_LEN2 = 17'h00080;
    localparam logic [MIN_W-1:0] MIN_LEN3 = 17'h00800;
    localparam logic [MIN_W-1:0] MIN_LEN4 = 17'h10000;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10ffff;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00d800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00dfff;

    typedef struct packed {
        logic [1:0]       pend;
        logic [CP_W-1:0]  acc;
        logic [MIN_W-1:0] min_cp;
        logic             have_first;
        logic             first_space;
        logic             last_space;
        logic             has_content;
        logic             err;
    } lbl_state_t;

    function automatic logic space_like(input logic [CP_W-1:0] c);
        return c == 21'h20 || c == 21'ha0 || (c >= 21'h2000 && c <= 21'h200a) ||
               c == 21'h2028 || c == 21'h2029 || c == 21'h202f ||
               c == 21'h205f || c == 21'h3000;
    endfunction

    function automatic logic forbidden(input logic [CP_W-1:0] c);
        return c < 21'h20 || (c >= 21'h7f && c <= 21'h9f) ||
               (c >= 21'h1f000 && c <= 21'h1ffff) ||
               (c >= 21'h2000 && c <= 21'h2fff) ||
               (c >= 21'hfe00 && c <= 21'hfeff) ||
               (c >= 21'he0000 && c <= 21'he0fff) ||
               (c >= 21'h202a && c <= 21'h202e) ||
               (c >= 21'h2066 && c <= 21'h2069);
    endfunction

endpackage

// ----- sv/utf8lv_decode.sv -----
// ----------------------------------------------------------------------------
// utf8lv_decode
// One-byte step of the label checker: decode, range checks, verdict.
// ----------------------------------------------------------------------------
module utf8lv_decode #(
    parameter int MAX_LABEL_BYTES = 63,
    parameter int CNT_W           = $clog2(MAX_LABEL_BYTES + 2)
) (
    input  utf8lv_pkg::lbl_state_t state_cur,
    input  logic [CNT_W-1:0]       count_cur,
    input  logic [7:0]             label_byte,
    input  logic                   has_byte,
    input  logic                   is_last,
    output utf8lv_pkg::lbl_state_t state_new,
    output logic [CNT_W-1:0]       count_new,
    output logic                   label_valid
);
    import utf8lv_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LABEL_BYTES);

    lbl_state_t       st;
    logic [CNT_W-1:0] cnt;
    logic [CP_W-1:0]  cp;
    logic [CP_W-1:0]  acc_shift;
    logic [MIN_W-1:0] cp_min;
    logic             cp_done;
    logic             cp_ok;
    logic             cp_space;

    assign acc_shift = {state_cur.acc[CP_W-7:0], label_byte[5:0]};

    always_comb
    begin
        st      = state_cur;
        cnt     = count_cur;
        cp      = '0;
        cp_min  = '0;
        cp_done = 1'b0;
        if (has_byte)
        begin
            if (count_cur <= MAX_CNT)
            begin
                cnt = count_cur + 1'b1;
            end
            if (cnt > MAX_CNT)
            begin
                st.err = 1'b1;
            end
            if (!st.err)
            begin
                if (state_cur.pend == 2'd0)
                begin
                    if (!label_byte[7])
                    begin
                        cp      = {13'd0, label_byte};
                        cp_done = 1'b1;
                    end
                    else if (label_byte >= LEAD2_LO && label_byte <= LEAD2_HI)
                    begin
                        st.acc    = {16'd0, label_byte[4:0]};
                        st.min_cp = MIN_LEN2;
                        st.pend   = 2'd1;
                    end
                    else if (label_byte >= LEAD3_LO && label_byte <= LEAD3_HI)
                    begin
                        st.acc    = {17'd0, label_byte[3:0]};
                        st.min_cp = MIN_LEN3;
                        st.pend   = 2'd2;
                    end
                    else if (label_byte >= LEAD4_LO && label_byte <= LEAD4_HI)
                    begin
                        st.acc    = {18'd0, label_byte[2:0]};
                        st.min_cp = MIN_LEN4;
                        st.pend   = 2'd3;
                    end
                    else
                    begin
                        st.err = 1'b1;
                    end
                end
                else if (label_byte[7:6] != 2'b10)
                begin
                    st.err = 1'b1;
                end
                else
                begin
                    st.acc  = acc_shift;
                    st.pend = state_cur.pend - 2'd1;
                    if (state_cur.pend == 2'd1)
                    begin
                        cp      = acc_shift;
                        cp_min  = state_cur.min_cp;
                        cp_done = 1'b1;
                    end
                end
            end
        end

        cp_ok    = ({4'd0, cp_min} <= cp) && (cp <= CP_MAX) &&
                   !(cp >= SURR_LO && cp <= SURR_HI) && !forbidden(cp);
        cp_space = space_like(cp);

        if (cp_done)
        begin
            if (!cp_ok)
            begin
                st.err = 1'b1;
            end
            else
            begin
                if (!st.have_first)
                begin
                    st.have_first  = 1'b1;
                    st.first_space = cp_space;
                end
                st.last_space = cp_space;
                if (!cp_space)
                begin
                    st.has_content = 1'b1;
                end
            end
        end

        if (cnt == '0 && !st.err)
        begin
            label_valid = 1'b1;
        end
        else
        begin
            label_valid = !st.err && st.pend == 2'd0 && st.has_content &&
                          st.have_first && !st.first_space && !st.last_space;
        end

        if (is_last)
        begin
            state_new = '0;
            count_new = '0;
        end
        else
        begin
            state_new = st;
            count_new = cnt;
        end
    end

endmodule

// ----- sv/utf8_label_validator.sv -----
// ----------------------------------------------------------------------------
// utf8_label_validator
// Streaming strict UTF-8 volume label checker, one byte per item.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while s_tready is high: each item sits in an input
// register, is decoded against the running label state in a single step and
// the verdict of the item flagged tlast goes into the output register as
// that item leaves the input register. Items other than the last give no
// output item. An empty label is one item with tuser low and tlast high.
// s_tready falls only when the output register is full, unread, and the item
// waiting in the input register closes a label.
module utf8_label_validator #(
    parameter int MAX_LABEL_BYTES = 63
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] label_byte
    input  logic       s_tuser,   // [0] has_byte
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] label_valid, [7:1] zero
);
    import utf8lv_pkg::*;

    localparam int CNT_W = $clog2(MAX_LABEL_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_LABEL_BYTES + 1);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_has_reg;
    logic             in_last_reg;
    logic             out_valid_reg;
    logic             out_label_reg;
    lbl_state_t       state_reg;
    lbl_state_t       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             verdict;
    logic             advance;

    utf8lv_decode #(
        .MAX_LABEL_BYTES (MAX_LABEL_BYTES),
        .CNT_W           (CNT_W)
    ) u_decode (
        .state_cur   (state_reg),
        .count_cur   (count_reg),
        .label_byte  (in_byte_reg),
        .has_byte    (in_has_reg),
        .is_last     (in_last_reg),
        .state_new   (state_next),
        .count_new   (count_next),
        .label_valid (verdict)
    );

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_label_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_has_reg  <= s_tuser;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
        begin
            out_label_reg <= verdict;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> state_reg == '0 && count_reg == '0)
        else $error("label state not cleared after last item");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_SAT)
        else $error("byte count beyond saturation");

    a_content_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.have_first |-> !state_reg.has_content && !state_reg.last_space)
        else $error("content recorded without a first character");

    a_pass_without_error: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg && verdict |-> !state_reg.err)
        else $error("label passed after an error");

    a_pass_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> m_tvalid && m_tdata[0] == $past(verdict))
        else $error("verdict lost on the way to the output register");
`endif

endmodule

// ----- tb/utf8_label_validator_tb.sv -----
// ----------------------------------------------------------------------------
// utf8_label_validator_tb
// Self-checking bench for the streaming UTF-8 volume label checker.
// ----------------------------------------------------------------------------
// A short directed run covers the empty label, bad leads, a bad continuation,
// overlong, out-of-range and surrogate forms, truncation, a zero byte, a
// blank-only label and an ignored item. Random labels follow, mostly well
// formed with random code points and some damaged. A predictor in the bench
// tracks the label state and queues one verdict per closing item; every
// output item is checked against the oldest queued verdict. Both sides idle
// in short bursts, the receiver holds off once for a long stretch and the
// sender now and then waits for all verdicts to come back.
module utf8_label_validator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import utf8lv_pkg::*;

    localparam int MAX_BYTES    = 63;
    localparam int TOTAL_ITEMS  = 1900;
    localparam int TAIL_ITEMS   = 150;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 100;
    localparam int DRAIN_EVERY  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    localparam logic [CP_W-1:0] BLANK_CPS [9] = '{
        21'h20, 21'ha0, 21'h2000, 21'h200a, 21'h2028,
        21'h2029, 21'h202f, 21'h205f, 21'h3000
    };
    localparam logic [CP_W-1:0] BAN_LO [9] = '{
        21'h0, 21'h7f, 21'h2000, 21'h202a, 21'h2066,
        21'hfe00, 21'h1f000, 21'he0000, 21'hd800
    };
    localparam logic [CP_W-1:0] BAN_HI [9] = '{
        21'h1f, 21'h9f, 21'h2fff, 21'h202e, 21'h2069,
        21'hfeff, 21'h1ffff, 21'he0fff, 21'hdfff
    };
    localparam logic [CP_W-1:0] EDGE_CPS [28] = '{
        21'h1f, 21'h7e, 21'h7f, 21'h9f, 21'ha0, 21'h1fff, 21'h3000,
        21'h2fff, 21'hd7ff, 21'hd800, 21'hdfff, 21'he000, 21'hfdff,
        21'hfe00, 21'hfeff, 21'hff00, 21'hffff, 21'h10000, 21'h1efff,
        21'h1f000, 21'h1ffff, 21'h20000, 21'hdffff, 21'he0000,
        21'he0fff, 21'he1000, 21'h10ffff, 21'h110000
    };

    typedef enum int {
        PT_PRINT, PT_BLANK, PT_TWO, PT_THREE, PT_FOUR,
        PT_BANNED, PT_ASCII, PT_EDGE, PT_OVERLONG, PT_BEYOND
    } point_class_t;

    typedef enum int {
        DMG_NONE, DMG_TRUNCATE, DMG_CORRUPT, DMG_INSERT, DMG_GARBAGE, DMG_EMPTY
    } damage_t;

    typedef struct packed {
        logic [7:0] octet;
        logic       present;
        logic       closes;
        logic       drain;
    } label_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] label_byte
    logic       s_tuser = 1'b0;    // [0] has_byte
    logic       s_tlast = 1'b0;    // is_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [0] label_valid, [7:1] zero

    label_item_t item_q [$];
    logic [7:0]  label_buf [$];
    logic        verdict_q [$];
    bit          noise_on = 1'b0;
    int          drain_mark = 300;
    int          mismatches = 0;
    int          items_in = 0;
    int          idle_run = 0;
    int          tick = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    // predicted label state
    logic [6:0]       seen_bytes = '0;
    logic [1:0]       cont_left = '0;
    logic [CP_W-1:0]  cp_acc = '0;
    logic [MIN_W-1:0] cp_floor = '0;
    logic [CP_W-1:0]  first_cp = '0;
    logic [CP_W-1:0]  last_cp = '0;
    logic             got_first = 1'b0;
    logic             got_content = 1'b0;
    logic             label_bad = 1'b0;

    utf8_label_validator #(
        .MAX_LABEL_BYTES(MAX_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic is_blank(input logic [CP_W-1:0] c);
        return c == 21'h20 || c == 21'ha0 || (c >= 21'h2000 && c <= 21'h200a) ||
               c == 21'h2028 || c == 21'h2029 || c == 21'h202f ||
               c == 21'h205f || c == 21'h3000;
    endfunction

    function automatic logic is_banned(input logic [CP_W-1:0] c);
        int k;
        for (k = 0; k < 8; k++)
        begin
            if (c >= BAN_LO[k] && c <= BAN_HI[k])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int natural_len(input logic [CP_W-1:0] c);
        if (c < 21'h80)
            return 1;
        if (c < 21'h800)
            return 2;
        if (c < 21'h10000)
            return 3;
        return 4;
    endfunction

    task automatic check_point(input logic [CP_W-1:0] c);
        if (c < CP_W'(cp_floor) || c > CP_MAX || (c >= SURR_LO && c <= SURR_HI) ||
            is_banned(c))
        begin
            label_bad = 1'b1;
        end
        else
        begin
            if (!got_first)
            begin
                first_cp = c;
                got_first = 1'b1;
            end
            last_cp = c;
            if (!is_blank(c))
                got_content = 1'b1;
        end
    endtask

    task automatic take_octet(input logic [7:0] b);
        if (seen_bytes < 7'(MAX_BYTES + 1))
            seen_bytes++;
        if (seen_bytes > 7'(MAX_BYTES))
            label_bad = 1'b1;
        if (label_bad)
            return;
        if (cont_left == 2'd0)
        begin
            if (!b[7])
            begin
                cp_floor = '0;
                check_point(CP_W'(b));
            end
            else if (b >= LEAD2_LO && b <= LEAD2_HI)
            begin
                cp_acc = CP_W'(b[4:0]);
                cp_floor = MIN_LEN2;
                cont_left = 2'd1;
            end
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
            begin
                cp_acc = CP_W'(b[3:0]);
                cp_floor = MIN_LEN3;
                cont_left = 2'd2;
            end
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
            begin
                cp_acc = CP_W'(b[2:0]);
                cp_floor = MIN_LEN4;
                cont_left = 2'd3;
            end
            else
            begin
                label_bad = 1'b1;
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            label_bad = 1'b1;
        end
        else
        begin
            cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
            cont_left--;
            if (cont_left == 2'd0)
                check_point(cp_acc);
        end
    endtask

    task automatic step_label(input logic [7:0] b, input logic present,
                              input logic closes, output logic gives,
                              output logic verdict);
        gives = 1'b0;
        verdict = 1'b0;
        if (present)
            take_octet(b);
        if (closes)
        begin
            gives = 1'b1;
            if (seen_bytes == '0 && !label_bad)
                verdict = 1'b1;
            else
                verdict = !label_bad && cont_left == 2'd0 && got_content && got_first &&
                          !is_blank(first_cp) && !is_blank(last_cp);
            seen_bytes = '0;
            cont_left = '0;
            cp_acc = '0;
            cp_floor = '0;
            first_cp = '0;
            last_cp = '0;
            got_first = 1'b0;
            got_content = 1'b0;
            label_bad = 1'b0;
        end
    endtask

    task automatic note_fail(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // ---- stimulus construction ----

    task automatic push_item(input logic [7:0] b, input logic present,
                             input logic closes, input logic drain);
        label_item_t it;
        it.octet = b;
        it.present = present;
        it.closes = closes;
        it.drain = drain;
        item_q.push_back(it);
    endtask

    task automatic close_label(input logic drain, input logic marker_end);
        int k;
        for (k = 0; k < label_buf.size(); k++)
        begin
            if (noise_on && $urandom_range(0, 24) == 0)
            begin
                push_item(8'($urandom), 1'b0, 1'b0, drain);
                drain = 1'b0;
            end
            push_item(label_buf[k], 1'b1, !marker_end && k == label_buf.size() - 1, drain);
            drain = 1'b0;
        end
        if (marker_end || label_buf.size() == 0)
            push_item(8'($urandom), 1'b0, 1'b1, drain);
    endtask

    // the low n bytes of seq, most significant byte first
    task automatic send_seq(input logic [31:0] seq, input int n);
        int k;
        label_buf.delete();
        for (k = n - 1; k >= 0; k--)
            label_buf.push_back(seq[8*k +: 8]);
        close_label(1'b0, 1'b0);
    endtask

    task automatic add_point(input logic [CP_W-1:0] c, input int n);
        case (n)
            1: label_buf.push_back(c[7:0]);
            2:
            begin
                label_buf.push_back({3'b110, c[10:6]});
                label_buf.push_back({2'b10, c[5:0]});
            end
            3:
            begin
                label_buf.push_back({4'b1110, c[15:12]});
                label_buf.push_back({2'b10, c[11:6]});
                label_buf.push_back({2'b10, c[5:0]});
            end
            default:
            begin
                label_buf.push_back({5'b11110, c[20:18]});
                label_buf.push_back({2'b10, c[17:12]});
                label_buf.push_back({2'b10, c[11:6]});
                label_buf.push_back({2'b10, c[5:0]});
            end
        endcase
    endtask

    task automatic pick_point();
        point_class_t cls;
        logic [CP_W-1:0] c;
        int roll;
        int idx;
        int n;
        roll = $urandom_range(0, 15);
        cls = (roll < 7) ? PT_PRINT : point_class_t'(roll - 6);
        n = 0;
        case (cls)
            PT_PRINT: c = CP_W'($urandom_range(8'h21, 8'h7e));
            PT_BLANK: c = BLANK_CPS[$urandom_range(0, 8)];
            PT_TWO: c = CP_W'($urandom_range(21'h80, 21'h7ff));
            PT_THREE: c = CP_W'($urandom_range(21'h800, 21'hffff));
            PT_FOUR: c = CP_W'($urandom_range(21'h10000, 21'h10ffff));
            PT_BANNED:
            begin
                idx = $urandom_range(0, 8);
                c = CP_W'($urandom_range(BAN_LO[idx], BAN_HI[idx]));
            end
            PT_ASCII: c = CP_W'($urandom_range(0, 8'h7f));
            PT_EDGE: c = EDGE_CPS[$urandom_range(0, 27)];
            PT_OVERLONG:
            begin
                n = $urandom_range(2, 4);
                c = CP_W'($urandom_range(0, (n == 2) ? 21'h7f : (n == 3) ? 21'h7ff : 21'hffff));
            end
            default:
            begin
                n = 4;
                c = CP_W'($urandom_range(21'h110000, 21'h1fffff));
            end
        endcase
        if (n == 0)
            n = natural_len(c);
        add_point(c, n);
    endtask

    task automatic printable_label(input int n);
        label_buf.delete();
        repeat (n)
            label_buf.push_back(8'($urandom_range(8'h21, 8'h7e)));
        close_label(1'b0, 1'b0);
    endtask

    task automatic random_label();
        damage_t dmg;
        int roll;
        int npts;
        logic drain;
        label_buf.delete();
        npts = ($urandom_range(0, 15) == 0) ? $urandom_range(14, 70) : $urandom_range(1, 6);
        repeat (npts)
            pick_point();
        roll = $urandom_range(0, 13);
        dmg = (roll < 6) ? damage_t'(roll) : DMG_NONE;
        case (dmg)
            DMG_TRUNCATE: void'(label_buf.pop_back());
            DMG_CORRUPT: label_buf[$urandom_range(0, label_buf.size() - 1)] = 8'($urandom);
            DMG_INSERT: label_buf.insert($urandom_range(0, label_buf.size()), 8'($urandom));
            DMG_GARBAGE:
            begin
                label_buf.delete();
                repeat ($urandom_range(1, 8))
                    label_buf.push_back(8'($urandom));
            end
            DMG_EMPTY: label_buf.delete();
            default: ;
        endcase
        drain = item_q.size() >= drain_mark;
        if (drain)
            drain_mark += DRAIN_EVERY;
        close_label(drain, $urandom_range(0, 15) == 0);
    endtask

    // ---- driver ----

    always @(posedge clk)
    begin
        label_item_t nxt;
        logic busy;
        busy = (tick % 768) < 512 && item_q.size() >= TAIL_ITEMS;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (item_q.size() == 0 ||
                     (item_q[0].drain && (s_tvalid || verdict_q.size() != 0)))
            begin
                s_tvalid <= 1'b0;
            end
            else if (busy && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 2);
                s_tvalid <= 1'b0;
            end
            else
            begin
                nxt = item_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= nxt.octet;
                s_tuser <= nxt.present;
                s_tlast <= nxt.closes;
            end
        end
    end

    // ---- receiver ----

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && items_in >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ((tick % 640) >= 128 && item_q.size() >= TAIL_ITEMS &&
                 $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // ---- prediction and checking ----

    always @(posedge clk)
    begin
        logic gives;
        logic verdict;
        logic [7:0] want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                items_in++;
                step_label(s_tdata, s_tuser, s_tlast, gives, verdict);
                if (gives)
                    verdict_q.push_back(verdict);
            end
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    note_fail($sformatf("output item with no verdict pending: m_tdata %02h",
                                        m_tdata));
                end
                else
                begin
                    want = {7'd0, verdict_q.pop_front()};
                    if (m_tdata !== want)
                        note_fail($sformatf("label_valid mismatch: expected %02h, got %02h",
                                            want, m_tdata));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        tick <= tick + 1;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
    end

    // ---- main sequence ----

    initial
    begin
        label_buf.delete();
        close_label(1'b0, 1'b0);            // empty label
        send_seq(32'h41, 1);                // plain letter
        send_seq(32'h00, 1);                // zero byte
        send_seq(32'hff, 1);                // bad lead, top
        send_seq(32'h80, 1);                // bad lead, stray continuation
        send_seq(32'he08080, 3);            // overlong three-byte form
        send_seq(32'hf4908080, 4);          // above the Unicode range
        send_seq(32'heda080, 3);            // surrogate
        send_seq(32'hc3, 1);                // truncated sequence
        send_seq(32'hc341, 2);              // bad continuation
        send_seq(32'h20, 1);                // blank only
        send_seq(32'hc3a9, 2);              // valid two-byte letter
        push_item(8'h41, 1'b1, 1'b0, 1'b0); // ignored item inside a label
        push_item(8'hff, 1'b0, 1'b0, 1'b0);
        push_item(8'h42, 1'b1, 1'b1, 1'b0);

        noise_on = 1'b1;
        printable_label(MAX_BYTES - 1);
        printable_label(MAX_BYTES);
        printable_label(MAX_BYTES + 1);
        while (item_q.size() < TOTAL_ITEMS)
            random_label();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (!(item_q.size() == 0 && !s_tvalid && verdict_q.size() == 0) &&
               idle_run < STALL_LIMIT)
            @(posedge clk);

        if (idle_run >= STALL_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
        end
        else
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (mismatches == 0 && verdict_q.size() == 0)
                $display("RESULT: OK");
            else
                $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/utf8lv_pkg.sv
sv/utf8lv_decode.sv
sv/utf8_label_validator.sv
tb/utf8_label_validator_tb.sv
